// ===== rtl/core/ubx_frame_receiver_top_defines.svh =====
// Assertion macros shared by the frame receiver checker.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef UBX_FRAME_RECEIVER_TOP_DEFINES_SVH
`define UBX_FRAME_RECEIVER_TOP_DEFINES_SVH

// Same-cycle implication, off during reset.
`define UBXR_ASSERT_NOW(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("ubxr check failed");

// Next-cycle implication, off during reset.
`define UBXR_ASSERT_NEXT(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("ubxr check failed");

`endif

// ===== rtl/core/ubxr_pkg.sv =====
// Shared types, codes and field tables for the UBX frame receiver.
// No dependencies; the queue, front, field stage, top level and checker import it.
package ubxr_pkg;

    // Framing and message identifiers
    localparam logic [7:0] SYNC_1      = 8'hB5;
    localparam logic [7:0] SYNC_2      = 8'h62;
    localparam logic [7:0] CLS_NAV     = 8'h01;
    localparam logic [7:0] CLS_SEC     = 8'h27;
    localparam logic [7:0] ID_UNIQID   = 8'h03;
    localparam logic [7:0] ID_TIMEUTC  = 8'h21;
    localparam logic [7:0] ID_PVT      = 8'h07;
    localparam logic [7:0] ID_POSLLH   = 8'h02;
    localparam logic [7:0] ID_SAT      = 8'h35;

    // Minimum payload lengths
    localparam logic [15:0] MIN_UNIQID  = 16'd9;
    localparam logic [15:0] MIN_TIMEUTC = 16'd19;
    localparam logic [15:0] MIN_PVT     = 16'd68;
    localparam logic [15:0] MIN_POSLLH  = 16'd28;
    localparam logic [15:0] MIN_SAT     = 16'd6;

    // Message kinds
    localparam logic [2:0] MK_UID  = 3'd0;
    localparam logic [2:0] MK_UTC  = 3'd1;
    localparam logic [2:0] MK_PVT  = 3'd2;
    localparam logic [2:0] MK_LLH  = 3'd3;
    localparam logic [2:0] MK_SAT  = 3'd4;

    // Field codes
    localparam logic [4:0] FC_YEAR     = 5'd0;
    localparam logic [4:0] FC_MONTH    = 5'd1;
    localparam logic [4:0] FC_DAY      = 5'd2;
    localparam logic [4:0] FC_HOUR     = 5'd3;
    localparam logic [4:0] FC_MINUTE   = 5'd4;
    localparam logic [4:0] FC_SECOND   = 5'd5;
    localparam logic [4:0] FC_FIX      = 5'd6;
    localparam logic [4:0] FC_NUMSV    = 5'd7;
    localparam logic [4:0] FC_LON      = 5'd8;
    localparam logic [4:0] FC_LAT      = 5'd9;
    localparam logic [4:0] FC_HEIGHT   = 5'd10;
    localparam logic [4:0] FC_HMSL     = 5'd11;
    localparam logic [4:0] FC_HACC     = 5'd12;
    localparam logic [4:0] FC_VACC     = 5'd13;
    localparam logic [4:0] FC_GSPEED   = 5'd14;
    localparam logic [4:0] FC_HEADING  = 5'd15;
    localparam logic [4:0] FC_SATCOUNT = 5'd16;
    localparam logic [4:0] FC_UID      = 5'd17;

    typedef enum logic [3:0] {
        PH_HUNT,
        PH_SYNC2,
        PH_CLASS,
        PH_IDENT,
        PH_LEN_LO,
        PH_LEN_HI,
        PH_PAYLOAD,
        PH_CK_A,
        PH_CK_B
    } phase_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_READ,
        B_LAST
    } bstate_t;

    // Front to queue
    typedef struct packed {
        logic       push;
        logic [2:0] kind;
    } qpush_t;

    // Queue to front
    typedef struct packed {
        logic full;
        logic wr_bank;
    } qstat_t;

    // Queue to back
    typedef struct packed {
        logic       avail;
        logic [2:0] kind;
        logic       bank;
    } qhead_t;

    typedef struct packed {
        logic       ok;
        logic [2:0] kind;
    } cls_t;

    // One field of a message: code, payload offset, byte count, sign, last mark
    typedef struct packed {
        logic [4:0] code;
        logic [6:0] off;
        logic [2:0] nbytes;
        logic       sgn;
        logic       last;
    } fdesc_t;

    function automatic cls_t classify(input logic [7:0] cls, input logic [7:0] ident,
                                      input logic [15:0] len);
        cls_t r;
        r.ok   = 1'b0;
        r.kind = MK_UID;
        if (cls == CLS_SEC && ident == ID_UNIQID) begin
            r.ok   = (len >= MIN_UNIQID);
            r.kind = MK_UID;
        end else if (cls == CLS_NAV && ident == ID_TIMEUTC) begin
            r.ok   = (len >= MIN_TIMEUTC);
            r.kind = MK_UTC;
        end else if (cls == CLS_NAV && ident == ID_PVT) begin
            r.ok   = (len >= MIN_PVT);
            r.kind = MK_PVT;
        end else if (cls == CLS_NAV && ident == ID_POSLLH) begin
            r.ok   = (len >= MIN_POSLLH);
            r.kind = MK_LLH;
        end else if (cls == CLS_NAV && ident == ID_SAT) begin
            r.ok   = (len >= MIN_SAT);
            r.kind = MK_SAT;
        end
        return r;
    endfunction

    function automatic fdesc_t mk_fd(input logic [4:0] code, input logic [6:0] off,
                                     input logic [2:0] nbytes, input logic sgn,
                                     input logic last);
        fdesc_t d;
        d.code   = code;
        d.off    = off;
        d.nbytes = nbytes;
        d.sgn    = sgn;
        d.last   = last;
        return d;
    endfunction

    // Field list of each message kind, in emission order
    function automatic fdesc_t field_desc(input logic [2:0] kind, input logic [3:0] idx);
        fdesc_t d;
        d = mk_fd(FC_SATCOUNT, 7'd5, 3'd1, 1'b0, 1'b1);
        case (kind)
            MK_UID: d = mk_fd(FC_UID, 7'd4, 3'd5, 1'b0, 1'b1);
            MK_UTC: begin
                case (idx)
                    4'd0:    d = mk_fd(FC_YEAR,   7'd12, 3'd2, 1'b0, 1'b0);
                    4'd1:    d = mk_fd(FC_MONTH,  7'd14, 3'd1, 1'b0, 1'b0);
                    4'd2:    d = mk_fd(FC_DAY,    7'd15, 3'd1, 1'b0, 1'b0);
                    4'd3:    d = mk_fd(FC_HOUR,   7'd16, 3'd1, 1'b0, 1'b0);
                    4'd4:    d = mk_fd(FC_MINUTE, 7'd17, 3'd1, 1'b0, 1'b0);
                    default: d = mk_fd(FC_SECOND, 7'd18, 3'd1, 1'b0, 1'b1);
                endcase
            end
            MK_PVT: begin
                case (idx)
                    4'd0:    d = mk_fd(FC_YEAR,    7'd4,  3'd2, 1'b0, 1'b0);
                    4'd1:    d = mk_fd(FC_MONTH,   7'd6,  3'd1, 1'b0, 1'b0);
                    4'd2:    d = mk_fd(FC_DAY,     7'd7,  3'd1, 1'b0, 1'b0);
                    4'd3:    d = mk_fd(FC_HOUR,    7'd8,  3'd1, 1'b0, 1'b0);
                    4'd4:    d = mk_fd(FC_MINUTE,  7'd9,  3'd1, 1'b0, 1'b0);
                    4'd5:    d = mk_fd(FC_SECOND,  7'd10, 3'd1, 1'b0, 1'b0);
                    4'd6:    d = mk_fd(FC_FIX,     7'd20, 3'd1, 1'b0, 1'b0);
                    4'd7:    d = mk_fd(FC_NUMSV,   7'd23, 3'd1, 1'b0, 1'b0);
                    4'd8:    d = mk_fd(FC_LON,     7'd24, 3'd4, 1'b1, 1'b0);
                    4'd9:    d = mk_fd(FC_LAT,     7'd28, 3'd4, 1'b1, 1'b0);
                    4'd10:   d = mk_fd(FC_HEIGHT,  7'd32, 3'd4, 1'b1, 1'b0);
                    4'd11:   d = mk_fd(FC_HMSL,    7'd36, 3'd4, 1'b1, 1'b0);
                    4'd12:   d = mk_fd(FC_HACC,    7'd40, 3'd4, 1'b0, 1'b0);
                    4'd13:   d = mk_fd(FC_VACC,    7'd44, 3'd4, 1'b0, 1'b0);
                    4'd14:   d = mk_fd(FC_GSPEED,  7'd60, 3'd4, 1'b1, 1'b0);
                    default: d = mk_fd(FC_HEADING, 7'd64, 3'd4, 1'b1, 1'b1);
                endcase
            end
            MK_LLH: begin
                case (idx)
                    4'd0:    d = mk_fd(FC_LON,    7'd4,  3'd4, 1'b1, 1'b0);
                    4'd1:    d = mk_fd(FC_LAT,    7'd8,  3'd4, 1'b1, 1'b0);
                    4'd2:    d = mk_fd(FC_HEIGHT, 7'd12, 3'd4, 1'b1, 1'b0);
                    4'd3:    d = mk_fd(FC_HMSL,   7'd16, 3'd4, 1'b1, 1'b0);
                    4'd4:    d = mk_fd(FC_HACC,   7'd20, 3'd4, 1'b0, 1'b0);
                    default: d = mk_fd(FC_VACC,   7'd24, 3'd4, 1'b0, 1'b1);
                endcase
            end
            default: d = mk_fd(FC_SATCOUNT, 7'd5, 3'd1, 1'b0, 1'b1);
        endcase
        return d;
    endfunction

endpackage

// ===== rtl/core/ubxr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ubxr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/core/ubxr_fifo.sv =====
// Two-entry queue of validated frames; entry slot doubles as capture bank.
// Depends on ubxr_pkg.
module ubxr_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  ubxr_pkg::qpush_t qpush,
    input  logic            pop,
    output ubxr_pkg::qstat_t qstat,
    output ubxr_pkg::qhead_t qhead
);
    import ubxr_pkg::*;

    logic [2:0] kind_q [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       full;
    logic       do_push;
    logic       do_pop;

    assign full    = (count_reg == 2'd2);
    assign do_push = qpush.push && !full;
    assign do_pop  = pop && (count_reg != 2'd0);

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            kind_q[wr_ptr_reg] <= qpush.kind;
        end
    end

    assign qstat.full    = full;
    assign qstat.wr_bank = wr_ptr_reg;
    assign qhead.avail   = (count_reg != 2'd0);
    assign qhead.kind    = kind_q[rd_ptr_reg];
    assign qhead.bank    = rd_ptr_reg;

endmodule

// ===== rtl/core/ubxr_front.sv =====
// Byte parser: sync hunt, header, payload capture and Fletcher-8 check.
// Depends on ubxr_pkg; writes payload into the capture RAM bank it is given.
module ubxr_front #(
    parameter int CAPTURE_DEPTH = 68,
    localparam int IDX_W        = $clog2(CAPTURE_DEPTH)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [7:0]       rx_byte,
    input  ubxr_pkg::qstat_t qstat,
    output ubxr_pkg::qpush_t qpush,
    output logic             wr_en,
    output logic [IDX_W:0]   wr_addr,
    output logic [7:0]       wr_data
);
    import ubxr_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [7:0]  class_reg;
    logic [7:0]  ident_reg;
    logic [15:0] len_reg;
    logic [15:0] cnt_reg;
    logic [7:0]  sum_a_reg, sum_a_next;
    logic [7:0]  sum_b_reg, sum_b_next;
    logic [7:0]  rsum_a_reg;

    logic        take;
    logic [15:0] len_full;
    logic [15:0] cnt_inc;
    logic        sums_match;
    cls_t        cls;

    logic clr_sum, acc_en, ld_class, ld_ident, ld_len_lo, ld_len_hi;
    logic cap_en, ld_rsum, chk_en;

    // Hold every byte while both capture banks wait on the field stage
    assign in_stall   = qstat.full;
    assign take       = in_valid && !qstat.full;
    assign len_full   = {rx_byte, len_reg[7:0]};
    assign cnt_inc    = cnt_reg + 16'd1;
    assign sum_a_next = sum_a_reg + rx_byte;
    assign sum_b_next = sum_b_reg + sum_a_next;
    assign sums_match = (rsum_a_reg == sum_a_reg) && (rx_byte == sum_b_reg);
    assign cls        = classify(class_reg, ident_reg, len_reg);

    always_comb
    begin
        phase_next = phase_reg;
        if (take)
        begin
            case (phase_reg)
                PH_HUNT:
                begin
                    if (rx_byte == SYNC_1)
                        phase_next = PH_SYNC2;
                end
                PH_SYNC2:
                begin
                    if (rx_byte == SYNC_2)
                        phase_next = PH_CLASS;
                    else if (rx_byte != SYNC_1)
                        phase_next = PH_HUNT;
                end
                PH_CLASS:   phase_next = PH_IDENT;
                PH_IDENT:   phase_next = PH_LEN_LO;
                PH_LEN_LO:  phase_next = PH_LEN_HI;
                PH_LEN_HI:  phase_next = (len_full != 16'd0) ? PH_PAYLOAD : PH_CK_A;
                PH_PAYLOAD:
                begin
                    if (cnt_inc >= len_reg)
                        phase_next = PH_CK_A;
                end
                PH_CK_A:    phase_next = PH_CK_B;
                PH_CK_B:    phase_next = PH_HUNT;
                default:    phase_next = PH_HUNT;
            endcase
        end
    end

    always_comb
    begin
        clr_sum   = 1'b0;
        acc_en    = 1'b0;
        ld_class  = 1'b0;
        ld_ident  = 1'b0;
        ld_len_lo = 1'b0;
        ld_len_hi = 1'b0;
        cap_en    = 1'b0;
        ld_rsum   = 1'b0;
        chk_en    = 1'b0;
        if (take)
        begin
            case (phase_reg)
                PH_SYNC2:   clr_sum = (rx_byte == SYNC_2);
                PH_CLASS:
                begin
                    acc_en   = 1'b1;
                    ld_class = 1'b1;
                end
                PH_IDENT:
                begin
                    acc_en   = 1'b1;
                    ld_ident = 1'b1;
                end
                PH_LEN_LO:
                begin
                    acc_en    = 1'b1;
                    ld_len_lo = 1'b1;
                end
                PH_LEN_HI:
                begin
                    acc_en    = 1'b1;
                    ld_len_hi = 1'b1;
                end
                PH_PAYLOAD:
                begin
                    acc_en = 1'b1;
                    cap_en = 1'b1;
                end
                PH_CK_A:    ld_rsum = 1'b1;
                PH_CK_B:    chk_en  = 1'b1;
                default:    chk_en  = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HUNT;
            class_reg  <= 8'd0;
            ident_reg  <= 8'd0;
            len_reg    <= 16'd0;
            cnt_reg    <= 16'd0;
            sum_a_reg  <= 8'd0;
            sum_b_reg  <= 8'd0;
            rsum_a_reg <= 8'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            if (clr_sum)
            begin
                sum_a_reg <= 8'd0;
                sum_b_reg <= 8'd0;
            end
            else if (acc_en)
            begin
                sum_a_reg <= sum_a_next;
                sum_b_reg <= sum_b_next;
            end
            if (ld_class)
                class_reg <= rx_byte;
            if (ld_ident)
                ident_reg <= rx_byte;
            if (ld_len_lo)
                len_reg <= {8'd0, rx_byte};
            if (ld_len_hi)
            begin
                len_reg <= len_full;
                cnt_reg <= 16'd0;
            end
            if (cap_en)
                cnt_reg <= cnt_inc;
            if (ld_rsum)
                rsum_a_reg <= rx_byte;
        end
    end

    // Drop payload bytes beyond the capture window
    assign wr_en   = cap_en && (cnt_reg < 16'(CAPTURE_DEPTH));
    assign wr_addr = {qstat.wr_bank, cnt_reg[IDX_W-1:0]};
    assign wr_data = rx_byte;

    assign qpush.push = chk_en && sums_match && cls.ok;
    assign qpush.kind = cls.kind;

endmodule

// ===== rtl/core/ubxr_back.sv =====
// Field stage: walks the field list of the queued frame, reads its bytes
// from the capture RAM and presents one field item at a time. Uses ubxr_pkg.
module ubxr_back #(
    parameter int CAPTURE_DEPTH = 68,
    localparam int IDX_W        = $clog2(CAPTURE_DEPTH)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  ubxr_pkg::qhead_t   qhead,
    output logic               pop,
    output logic               rd_en,
    output logic [IDX_W:0]     rd_addr,
    input  logic [7:0]         rd_data,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         message_kind,
    output logic [4:0]         field_code,
    output logic signed [40:0] field_value,
    output logic               last_field
);
    import ubxr_pkg::*;

    bstate_t     state_reg, state_next;
    logic [3:0]  fidx_reg;
    logic [2:0]  bidx_reg;
    logic [31:0] acc_reg;
    logic        out_valid_reg;
    logic [2:0]  kind_reg;
    logic [4:0]  code_reg;
    logic [40:0] value_reg;
    logic        last_reg;

    fdesc_t      desc;
    logic        out_free;
    logic        load_out;
    logic [2:0]  last_pos;
    logic [1:0]  cap_pos;
    logic [6:0]  byte_off;
    logic [39:0] acc_ext;
    logic [39:0] raw;
    logic [40:0] value;

    assign desc     = field_desc(qhead.kind, fidx_reg);
    assign out_free = !out_valid_reg || !out_stall;
    assign last_pos = desc.nbytes - 3'd1;
    assign cap_pos  = 2'(bidx_reg - 3'd1);
    assign byte_off = desc.off + {4'd0, bidx_reg};
    assign acc_ext  = {8'd0, acc_reg};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (qhead.avail)
                    state_next = B_READ;
            end
            B_READ:
            begin
                if (bidx_reg == last_pos)
                    state_next = B_LAST;
            end
            B_LAST:
            begin
                if (out_free)
                    state_next = desc.last ? B_IDLE : B_READ;
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        rd_en    = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            B_READ:  rd_en    = 1'b1;
            B_LAST:  load_out = out_free;
            default: rd_en    = 1'b0;
        endcase
    end

    assign pop     = load_out && desc.last;
    assign rd_addr = {qhead.bank, IDX_W'(byte_off)};

    // Assemble the little-endian field; the top byte comes straight off the RAM
    always_comb
    begin
        raw = 40'd0;
        for (int i = 0; i < 5; i++)
        begin
            if (3'(i) == last_pos)
                raw[i*8 +: 8] = rd_data;
            else if (3'(i) < last_pos)
                raw[i*8 +: 8] = acc_ext[i*8 +: 8];
        end
        value = desc.sgn ? {{9{raw[31]}}, raw[31:0]} : {1'b0, raw};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            fidx_reg      <= 4'd0;
            bidx_reg      <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                B_IDLE:
                begin
                    fidx_reg <= 4'd0;
                    bidx_reg <= 3'd0;
                end
                B_READ:  bidx_reg <= bidx_reg + 3'd1;
                B_LAST:
                begin
                    if (load_out)
                    begin
                        fidx_reg <= desc.last ? 4'd0 : fidx_reg + 4'd1;
                        bidx_reg <= 3'd0;
                    end
                end
                default: bidx_reg <= 3'd0;
            endcase
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        // Keep the byte that arrived from the previous read of this field
        if (state_reg == B_READ && bidx_reg != 3'd0)
            acc_reg[cap_pos*8 +: 8] <= rd_data;
        if (load_out)
        begin
            kind_reg  <= qhead.kind;
            code_reg  <= desc.code;
            value_reg <= value;
            last_reg  <= desc.last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign message_kind = kind_reg;
    assign field_code   = code_reg;
    assign field_value  = value_reg;
    assign last_field   = last_reg;

endmodule

// ===== rtl/core/ubx_frame_receiver_top.sv =====
// UBX frame receiver. Takes one serial-link byte per item and, for each
// frame whose two Fletcher-8 checksum bytes match and that is a known,
// long-enough unique-id, UTC time, PVT, POSLLH or satellite message, emits
// one item per field (kind, field code, little-endian value, last mark).
// Input rate: one byte per cycle. in_stall rises only while two validated
// frames are still waiting for their fields to be sent; the capture RAM has
// two banks, one per queued frame, and a third frame's bytes are held off.
// Output: the payload bytes of a field are read one by one through the
// single read port of the capture RAM before its item is presented, so a
// PVT frame drains well inside its 76 input bytes unless the output stalls.
// The capture RAM needs no clearing after reset: only bytes written earlier
// in the same frame are ever read.
// Depends on ubxr_pkg, ubxr_ram, ubxr_fifo, ubxr_front and ubxr_back.
module ubx_frame_receiver_top #(
    parameter int CAPTURE_DEPTH = 68
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         rx_byte,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         message_kind,
    output logic [4:0]         field_code,
    output logic signed [40:0] field_value,
    output logic               last_field
);
    import ubxr_pkg::*;

    localparam int IDX_W     = $clog2(CAPTURE_DEPTH);
    localparam int RAM_DEPTH = 2 ** (IDX_W + 1);

    qpush_t          qpush;
    qstat_t          qstat;
    qhead_t          qhead;
    logic            pop;
    logic            wr_en;
    logic [IDX_W:0]  wr_addr;
    logic [7:0]      wr_data;
    logic            rd_en;
    logic [IDX_W:0]  rd_addr;
    logic [7:0]      rd_data;

    // Front: parse bytes, check the sum, push validated frames
    ubxr_front #(
        .CAPTURE_DEPTH (CAPTURE_DEPTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .rx_byte  (rx_byte),
        .qstat    (qstat),
        .qpush    (qpush),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data)
    );

    // Queue of validated frames; its slot picks the capture bank
    ubxr_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .qpush (qpush),
        .pop   (pop),
        .qstat (qstat),
        .qhead (qhead)
    );

    // Capture RAM: bank bit on top, payload index below
    ubxr_ram #(
        .WIDTH (8),
        .DEPTH (RAM_DEPTH)
    ) u_capture (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Back: read fields of the head frame and present them
    ubxr_back #(
        .CAPTURE_DEPTH (CAPTURE_DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .qhead        (qhead),
        .pop          (pop),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .message_kind (message_kind),
        .field_code   (field_code),
        .field_value  (field_value),
        .last_field   (last_field)
    );

endmodule

// ===== rtl/core/ubxr_checker.sv =====
// Port-level checks for the frame receiver, bound to the top level.
// Depends on ubxr_pkg and ubx_frame_receiver_top_defines.svh.
`include "ubx_frame_receiver_top_defines.svh"

module ubxr_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_stall,
    input logic [2:0]         message_kind,
    input logic [4:0]         field_code,
    input logic signed [40:0] field_value,
    input logic               last_field
);
    import ubxr_pkg::*;

    // A stalled item holds
    `UBXR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(field_value) && $stable(field_code) && $stable(last_field))

    // Single-field messages carry their own field and close the frame
    `UBXR_ASSERT_NOW(a_uid_single, out_valid && message_kind == MK_UID, field_code == FC_UID && last_field)

    `UBXR_ASSERT_NOW(a_sat_single, out_valid && message_kind == MK_SAT, field_code == FC_SATCOUNT && last_field && field_value[40:8] == 33'd0)

    // Signed 32-bit fields are sign-extended
    `UBXR_ASSERT_NOW(a_sign_ext, out_valid && (field_code == FC_LON || field_code == FC_LAT || field_code == FC_HEIGHT || field_code == FC_HMSL || field_code == FC_GSPEED || field_code == FC_HEADING), field_value[40:31] == 10'h000 || field_value[40:31] == 10'h3FF)

endmodule

bind ubx_frame_receiver_top ubxr_checker u_checker (.*);
